FILE: design/salru_pkg.sv
// Shared constants, types and helpers for the set-associative LRU tag store.
`default_nettype none

package salru_pkg;

    // Default sizes
    localparam int DEF_WAYS      = 8;
    localparam int DEF_SET_BITS  = 8;
    localparam int DEF_ADDR_BITS = 48;

    // Evicted address is reported on at most this many low bits
    localparam int EV_BITS = 48;

    // Field widths
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_INVAL  = 2'd3;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd1;
    localparam logic [CFG_W-1:0]     RST_WAYS     = 4'd8;
    localparam logic [CFG_W-1:0]     RST_SET_BITS = 4'd8;

    // Status of one set update
    typedef struct packed {
        logic hit;
        logic evict;
        logic tag_we;
    } upd_flags_t;

    // Bits needed to number n ways (at least one)
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

FILE: design/salru_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/salru_set_upd.sv
// Set update: parallel tag compare, victim pick and recency rank rewrite.
`default_nettype none

module salru_set_upd #(
    parameter int WAYS      = salru_pkg::DEF_WAYS,
    parameter int ADDR_BITS = salru_pkg::DEF_ADDR_BITS,
    parameter int RANK_W    = salru_pkg::idx_width(WAYS)
) (
    input  wire logic [salru_pkg::ACT_W-1:0]         action,
    input  wire logic [ADDR_BITS-1:0]                address,
    input  wire logic [WAYS-1:0]                     in_use,
    input  wire logic [WAYS-1:0]                     valid,
    input  wire logic [WAYS-1:0][RANK_W-1:0]         rank,
    input  wire logic [WAYS-1:0][ADDR_BITS-1:0]      tag,
    output logic      [WAYS-1:0]                     new_valid,
    output logic      [WAYS-1:0][RANK_W-1:0]         new_rank,
    output logic      [WAYS-1:0][ADDR_BITS-1:0]      new_tag,
    output logic      [ADDR_BITS-1:0]                ev_addr,
    output salru_pkg::upd_flags_t                    flags
);

    import salru_pkg::*;

    localparam logic [RANK_W-1:0] RankMax = RANK_W'(WAYS - 1);

    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   free;
    logic [WAYS-1:0]   is_max;
    logic [RANK_W-1:0] found_way;
    logic [RANK_W-1:0] free_way;
    logic [RANK_W-1:0] victim_way;
    logic [RANK_W-1:0] pway;
    logic [RANK_W-1:0] old_rank;
    logic              found_any;
    logic              free_any;
    logic              do_promote;
    logic              do_fill;
    logic              do_evict;
    logic              do_inval;

    // compares and oldest-way flags, each way independent
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]  = in_use[i] & valid[i] & (tag[i] == address);
            free[i]   = in_use[i] & ~valid[i];
            is_max[i] = in_use[i];
            for (int j = 0; j < WAYS; j++)
            begin
                if (in_use[j] && (rank[j] > rank[i]))
                begin
                    is_max[i] = 1'b0;
                end
            end
        end
    end

    // lowest-numbered way wins in each group
    always_comb
    begin
        found_way  = '0;
        free_way   = '0;
        victim_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_way = RANK_W'(i);
            end
            if (free[i])
            begin
                free_way = RANK_W'(i);
            end
            if (is_max[i])
            begin
                victim_way = RANK_W'(i);
            end
        end
    end

    assign found_any  = |match;
    assign free_any   = |free;
    // insert of a present address behaves as a touch
    assign do_promote = ((action == ACT_TOUCH) || (action == ACT_INSERT)) && found_any;
    assign do_fill    = (action == ACT_INSERT) && !found_any && free_any;
    assign do_evict   = (action == ACT_INSERT) && !found_any && !free_any;
    assign do_inval   = (action == ACT_INVAL) && found_any;
    assign pway       = do_evict ? victim_way : found_way;
    assign old_rank   = rank[pway];

    always_comb
    begin
        new_valid = valid;
        new_rank  = rank;
        new_tag   = tag;
        for (int i = 0; i < WAYS; i++)
        begin
            if (in_use[i])
            begin
                if (do_promote || do_evict)
                begin
                    if (RANK_W'(i) == pway)
                    begin
                        new_rank[i] = '0;
                    end
                    else if (valid[i] && (rank[i] < old_rank) && (rank[i] < RankMax))
                    begin
                        new_rank[i] = rank[i] + 1'b1;
                    end
                end
                if (do_evict && (RANK_W'(i) == pway))
                begin
                    new_tag[i] = address;
                end
                if (do_fill)
                begin
                    if (RANK_W'(i) == free_way)
                    begin
                        new_tag[i]   = address;
                        new_valid[i] = 1'b1;
                        new_rank[i]  = '0;
                    end
                    else if (valid[i] && (rank[i] < RankMax))
                    begin
                        new_rank[i] = rank[i] + 1'b1;
                    end
                end
                if (do_inval)
                begin
                    if (RANK_W'(i) == found_way)
                    begin
                        new_valid[i] = 1'b0;
                        new_rank[i]  = '0;
                    end
                    else if (valid[i] && (rank[i] > old_rank))
                    begin
                        new_rank[i] = rank[i] - 1'b1;
                    end
                end
            end
        end
    end

    assign ev_addr      = do_evict ? tag[victim_way] : '0;
    assign flags.hit    = found_any;
    assign flags.evict  = do_evict;
    assign flags.tag_we = do_fill | do_evict;

endmodule

`default_nettype wire

FILE: design/set_assoc_lru_tag_store_unit.sv
// Top level of the set-associative tag store with true LRU replacement.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_ready, action, address           | item in
//  out     | out_valid, out_ready, hit, evicted_valid,     | item out
//          | evicted_address                               |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data     | reg write
//
// Each item first reads its set row from the tag and rank memories, then
// compares, updates ranks and writes the row back.
// After reset a clearing pass zeroes the rank/valid memory, one set a cycle,
// over all 2**SET_BITS sets (256 by default); no item is taken meanwhile.
// A finished item waits in the output register; the next item is still taken
// and holds in its update cycle until the output register frees up.
`default_nettype none

module set_assoc_lru_tag_store_unit #(
    parameter int WAYS      = salru_pkg::DEF_WAYS,
    parameter int SET_BITS  = salru_pkg::DEF_SET_BITS,
    parameter int ADDR_BITS = salru_pkg::DEF_ADDR_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [salru_pkg::ACT_W-1:0]       action,
    input  wire logic [ADDR_BITS-1:0]              address,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   hit,
    output logic                                   evicted_valid,
    output logic      [ADDR_BITS-1:0]              evicted_address,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [salru_pkg::CFG_W-1:0]       cfg_data
);

    import salru_pkg::*;

    localparam int IdxW  = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int Sets  = 1 << SET_BITS;
    localparam int RankW = idx_width(WAYS);
    localparam int MetaW = WAYS * (RankW + 1);
    localparam int TagW  = WAYS * ADDR_BITS;
    localparam int ExtW  = (ADDR_BITS > IdxW) ? ADDR_BITS : IdxW;
    localparam int NwW   = CFG_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BUSY  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IdxW-1:0]      clr_cnt_reg;
    logic [CFG_W-1:0]     cfg_ways_reg;
    logic [CFG_W-1:0]     cfg_set_bits_reg;
    logic [ACT_W-1:0]     act_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [IdxW-1:0]      set_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic                 ev_valid_reg;
    logic [ADDR_BITS-1:0] ev_addr_reg;

    logic                 accept;
    logic                 done;
    logic                 clr_last;
    logic [ExtW-1:0]      addr_ext;
    logic [IdxW-1:0]      set_idx;
    logic [NwW-1:0]       nw;
    logic [WAYS-1:0]      in_use;

    logic                 meta_we;
    logic [IdxW-1:0]      meta_waddr;
    logic [MetaW-1:0]     meta_wdata;
    logic [MetaW-1:0]     meta_rdata;
    logic                 tag_we;
    logic [TagW-1:0]      tag_rdata;

    logic [WAYS-1:0]                 row_valid;
    logic [WAYS-1:0][RankW-1:0]      row_rank;
    logic [WAYS-1:0][ADDR_BITS-1:0]  row_tag;
    logic [WAYS-1:0]                 upd_valid;
    logic [WAYS-1:0][RankW-1:0]      upd_rank;
    logic [WAYS-1:0][ADDR_BITS-1:0]  upd_tag;
    logic [ADDR_BITS-1:0]            upd_ev_addr;
    logic [ADDR_BITS-1:0]            ev_masked;
    upd_flags_t                      upd_flags;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign done      = !out_valid_reg || out_ready;
    assign clr_last  = (clr_cnt_reg == IdxW'(Sets - 1));
    assign cfg_ready = 1'b1;

    // set index: low address bits, limited by the register and SET_BITS
    assign addr_ext = ExtW'(address);
    always_comb
    begin
        for (int b = 0; b < IdxW; b++)
        begin
            set_idx[b] = (b < SET_BITS) && (b < int'(cfg_set_bits_reg)) && addr_ext[b];
        end
    end

    // ways in use, clamped to 1..WAYS
    always_comb
    begin
        if (cfg_ways_reg == '0)
        begin
            nw = NwW'(1);
        end
        else if (NwW'(cfg_ways_reg) > NwW'(WAYS))
        begin
            nw = NwW'(WAYS);
        end
        else
        begin
            nw = NwW'(cfg_ways_reg);
        end
        for (int i = 0; i < WAYS; i++)
        begin
            in_use[i] = (NwW'(i) < nw);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            cfg_ways_reg     <= RST_WAYS;
            cfg_set_bits_reg <= RST_SET_BITS;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WAYS:     cfg_ways_reg     <= cfg_data;
                    CFG_SET_BITS: cfg_set_bits_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if ((state_reg == ST_BUSY) && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            addr_reg <= address;
            set_reg  <= set_idx;
        end
        if ((state_reg == ST_BUSY) && done)
        begin
            hit_reg      <= upd_flags.hit;
            ev_valid_reg <= upd_flags.evict;
            ev_addr_reg  <= ev_masked;
        end
    end

    // memory write side: clearing pass or set write-back
    assign meta_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_BUSY) && done);
    assign meta_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign meta_wdata = (state_reg == ST_CLEAR) ? '0 : {upd_valid, upd_rank};
    assign tag_we     = (state_reg == ST_BUSY) && done && upd_flags.tag_we;

    salru_ram #(
        .WIDTH (MetaW),
        .DEPTH (Sets),
        .AW    (IdxW)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (set_idx),
        .rdata (meta_rdata)
    );

    salru_ram #(
        .WIDTH (TagW),
        .DEPTH (Sets),
        .AW    (IdxW)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (set_reg),
        .wdata (upd_tag),
        .re    (accept),
        .raddr (set_idx),
        .rdata (tag_rdata)
    );

    assign row_valid = meta_rdata[MetaW-1 -: WAYS];
    assign row_rank  = meta_rdata[WAYS*RankW-1:0];
    assign row_tag   = tag_rdata;

    salru_set_upd #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS),
        .RANK_W    (RankW)
    ) u_set_upd (
        .action    (act_reg),
        .address   (addr_reg),
        .in_use    (in_use),
        .valid     (row_valid),
        .rank      (row_rank),
        .tag       (row_tag),
        .new_valid (upd_valid),
        .new_rank  (upd_rank),
        .new_tag   (upd_tag),
        .ev_addr   (upd_ev_addr),
        .flags     (upd_flags)
    );

    always_comb
    begin
        for (int b = 0; b < ADDR_BITS; b++)
        begin
            ev_masked[b] = (b < EV_BITS) ? upd_ev_addr[b] : 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_address = ev_addr_reg;

    // an accepted item blocks further input for its update cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken during set update");

    // an eviction only follows a miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid))
        else $error("eviction reported on a hit");

    // no eviction, no address
    a_ev_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted_valid) |-> (evicted_address == '0))
        else $error("evicted address set without eviction");

    // an update with a free output slot always delivers next cycle
    a_busy_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BUSY) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished item not delivered");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for the set-associative LRU tag store: directed cases, then randomised traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salru_pkg::*;

    localparam int WAYS          = DEF_WAYS;
    localparam int SET_BITS      = DEF_SET_BITS;
    localparam int ADDR_BITS     = DEF_ADDR_BITS;
    localparam int ENTRIES       = (1 << SET_BITS) * WAYS;
    localparam int RANK_W        = $clog2(WAYS);
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 16;
    localparam int N_PHASES      = 10;
    localparam int PHASE_ITEMS   = 78;
    localparam int POOL_MAX      = 18;

    // Register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [ADDR_BITS-1:0] evicted_address;
    } lru_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ACT_W-1:0]     action = ACT_LOOKUP;
    logic [ADDR_BITS-1:0] address = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic                 evicted_valid;
    logic [ADDR_BITS-1:0] evicted_address;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WAYS;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor state
    logic [ADDR_BITS-1:0] model_tag   [ENTRIES];
    bit                   model_valid [ENTRIES];
    logic [RANK_W-1:0]    model_rank  [ENTRIES];
    logic [CFG_W-1:0]     model_ways;
    logic [CFG_W-1:0]     model_set_bits;

    lru_result_t pending_results[$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  hits_seen = 0;
    int  evictions_seen = 0;
    int  settings_used = 1;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;

    int phase_ways  [N_PHASES] = '{8, 1, 0, 15, 4, 2, 8, 3, 6, 5};
    int phase_sbits [N_PHASES] = '{8, 0, 2, 15, 1, 8, 0, 3, 12, 2};

    set_assoc_lru_tag_store_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .evicted_valid   (evicted_valid),
        .evicted_address (evicted_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_address();
        return ADDR_BITS'({$urandom, $urandom});
    endfunction

    // Way w becomes MRU; valid ways younger than it age by one
    task automatic promote_way(input int base, input int nw, input int w);
        logic [RANK_W-1:0] old_rank;
        old_rank = model_rank[base + w];
        for (int i = 0; i < nw; i++) begin
            if (i != w && model_valid[base + i] && model_rank[base + i] < old_rank) begin
                if (model_rank[base + i] < RANK_W'(WAYS - 1))
                    model_rank[base + i]++;
            end
        end
        model_rank[base + w] = '0;
    endtask

    task automatic apply_item(input logic [ACT_W-1:0] act, input logic [ADDR_BITS-1:0] addr,
                              output lru_result_t res);
        int nw;
        int sb;
        int base;
        int found;
        int free_way;
        int victim;
        logic [RANK_W-1:0] old_rank;
        nw = (model_ways < 1) ? 1 : ((model_ways > WAYS) ? WAYS : int'(model_ways));
        sb = (model_set_bits > SET_BITS) ? SET_BITS : int'(model_set_bits);
        base = int'(addr & ((ADDR_BITS'(1) << sb) - 1)) * WAYS;
        found = -1;
        free_way = -1;
        victim = 0;
        res = '0;
        for (int i = 0; i < nw; i++) begin
            if (found < 0 && model_valid[base + i] && model_tag[base + i] == addr)
                found = i;
        end
        if (act == ACT_TOUCH || (act == ACT_INSERT && found >= 0)) begin
            if (found >= 0)
                promote_way(base, nw, found);
        end else if (act == ACT_INSERT) begin
            for (int i = 0; i < nw; i++) begin
                if (free_way < 0 && !model_valid[base + i])
                    free_way = i;
            end
            if (free_way >= 0) begin
                for (int i = 0; i < nw; i++) begin
                    if (model_valid[base + i] && model_rank[base + i] < RANK_W'(WAYS - 1))
                        model_rank[base + i]++;
                end
                model_tag[base + free_way] = addr;
                model_valid[base + free_way] = 1'b1;
                model_rank[base + free_way] = '0;
            end else begin
                // ties go to the lowest-numbered way
                for (int i = 1; i < nw; i++) begin
                    if (model_rank[base + i] > model_rank[base + victim])
                        victim = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_address = model_tag[base + victim];
                model_tag[base + victim] = addr;
                promote_way(base, nw, victim);
            end
        end else if (act == ACT_INVAL && found >= 0) begin
            old_rank = model_rank[base + found];
            model_valid[base + found] = 1'b0;
            model_rank[base + found] = '0;
            for (int i = 0; i < nw; i++) begin
                if (model_valid[base + i] && model_rank[base + i] > old_rank)
                    model_rank[base + i]--;
            end
        end
        res.hit = (found >= 0);
    endtask

    // Leaves in_valid high on return so that a back-to-back item needs no re-raise
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ADDR_BITS-1:0] addr);
        int gap;
        lru_result_t res;
        gap = src_idle_en ? gap_cycles() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_item(act, addr, res);
        pending_results.insert(pending_results.size(), res);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WAYS)
            model_ways = val;
        else if (idx == CFG_SET_BITS)
            model_set_bits = val;
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every outstanding item come back, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        logic [ADDR_BITS-1:0] all_ones;
        all_ones = '1;
        send_item(ACT_LOOKUP, '0);
        send_item(ACT_INSERT, '0);
        send_item(ACT_INSERT, all_ones);
        send_item(ACT_LOOKUP, all_ones);
        send_item(ACT_LOOKUP, '0);
        // touch of an absent address
        send_item(ACT_TOUCH, ADDR_BITS'(1 * 256 + 5));
        for (int k = 1; k <= 8; k++)
            send_item(ACT_INSERT, ADDR_BITS'(k * 256 + 5));
        // insert of a present address acts as a touch
        send_item(ACT_INSERT, ADDR_BITS'(1 * 256 + 5));
        send_item(ACT_INSERT, ADDR_BITS'(9 * 256 + 5));
        send_item(ACT_TOUCH, ADDR_BITS'(3 * 256 + 5));
        send_item(ACT_INSERT, ADDR_BITS'(2 * 256 + 5));
        send_item(ACT_INVAL, ADDR_BITS'(5 * 256 + 5));
        send_item(ACT_INVAL, ADDR_BITS'(5 * 256 + 5));
        // refills the way just freed
        send_item(ACT_INSERT, ADDR_BITS'(4 * 256 + 5));
        send_item(ACT_LOOKUP, ADDR_BITS'(5 * 256 + 5));
        send_item(ACT_INVAL, all_ones);
        send_item(ACT_TOUCH, '0);
    endtask

    // One register setting; addresses crowd into a few sets so that ways fill and evict
    task automatic test_random_traffic(input int p);
        logic [ADDR_BITS-1:0] addr_pool [POOL_MAX];
        logic [7:0]           set_pick [3];
        logic [ADDR_BITS-1:0] addr;
        logic [ACT_W-1:0]     act;
        int eff_ways;
        int pool_n;
        int n_sets;
        int r;
        wait_idle();
        if (p == 0) begin
            cfg_write(CFG_SPARE_2, CFG_W'($urandom), 1'b0);
            cfg_write(CFG_SPARE_3, CFG_W'($urandom), 1'b0);
        end
        cfg_write(CFG_WAYS, CFG_W'(phase_ways[p]), 1'b0);
        cfg_write(CFG_SET_BITS, CFG_W'(phase_sbits[p]), 1'b1);
        settings_used++;
        src_idle_en = (p % 4 == 0) || (p % 4 == 2);
        sink_idle_en = (p % 4 == 0) || (p % 4 == 3);
        eff_ways = (phase_ways[p] < 1) ? 1 : ((phase_ways[p] > WAYS) ? WAYS : phase_ways[p]);
        pool_n = 2 * eff_ways + 2;
        if (pool_n > POOL_MAX)
            pool_n = POOL_MAX;
        n_sets = $urandom_range(1, 3);
        for (int k = 0; k < 3; k++)
            set_pick[k] = 8'($urandom);
        for (int k = 0; k < pool_n; k++) begin
            addr = random_address();
            addr[7:0] = set_pick[$urandom_range(0, n_sets - 1)];
            addr_pool[k] = addr;
        end
        repeat (PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                act = ACT_INSERT;
            else if (r < 60)
                act = ACT_LOOKUP;
            else if (r < 80)
                act = ACT_TOUCH;
            else
                act = ACT_INVAL;
            if ($urandom_range(0, 99) < 85)
                addr = addr_pool[$urandom_range(0, pool_n - 1)];
            else
                addr = random_address();
            send_item(act, addr);
        end
    endtask

    always @(posedge clk) begin : result_check
        lru_result_t exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no item outstanding");
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (hit !== exp_res.hit) begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, hit);
                    fail_count++;
                end
                if (evicted_valid !== exp_res.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           exp_res.evicted_valid, evicted_valid);
                    fail_count++;
                end
                if (evicted_address !== exp_res.evicted_address) begin
                    $error("evicted_address: expected %0h, got %0h",
                           exp_res.evicted_address, evicted_address);
                    fail_count++;
                end
                if (exp_res.hit)
                    hits_seen++;
                if (exp_res.evicted_valid)
                    evictions_seen++;
            end
        end
    end

    initial begin : sink_driver
        int g;
        @(posedge clk);
        forever begin
            g = sink_idle_en ? gap_cycles() : 0;
            if (g == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // Covers the clearing pass after reset as well as the longest stalls
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            model_tag[i] = '0;
            model_valid[i] = 1'b0;
            model_rank[i] = '0;
        end
        model_ways = RST_WAYS;
        model_set_bits = RST_SET_BITS;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        for (int p = 0; p < N_PHASES; p++)
            test_random_traffic(p);
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("Ran %0d items over %0d register settings (ways 0..15, set bits 0..15).",
                 items_sent, settings_used);
        $display("Checked results included %0d hits and %0d evictions.",
                 hits_seen, evictions_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
